// ===== hw/rtl/range_segment_table_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef RANGE_SEGMENT_TABLE_DEFINES_SVH
`define RANGE_SEGMENT_TABLE_DEFINES_SVH

// Clocked assertion, masked while reset is asserted.
`define RSEG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define RSEG_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/rseg_pkg.sv =====
package rseg_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam int ADDR_W      = 64;
	localparam int OP_W        = 2;
	localparam int STAT_W      = 2;
	localparam int IN_DATA_W   = 3 * ADDR_W;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_OVERLAP = 2'd1;
	localparam logic [STAT_W-1:0] STAT_ABSENT  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd3;

	typedef struct packed {
		logic [ADDR_W-1:0] start_addr;
		logic [ADDR_W-1:0] end_addr;
		logic [ADDR_W-1:0] handle;
	} entry_t;

endpackage

// ===== hw/rtl/range_segment_table.sv =====
// range_segment_table: table of disjoint address segments (start, end, handle).
// Input channel s_*: one request item per handshake. s_tuser carries the operation
// (insert, find, delete); s_tdata carries base, size and handle. Output channel
// m_*: exactly one result item per request, status in m_tuser, handle in m_tdata.
// Each request scans every table slot through the single read port of the entry
// memory, one slot per cycle. A result is loaded once the scan is complete, and
// s_tready rises with it, so the next request is taken only after that: the block
// scans one request at a time; the slot scan over the one read port sets the rate.
// Segments that merely touch count as overlapping; the end is base + size mod 2^64.
// Insert goes to the lowest free slot; a full table reports table full.
// Reset clears all valid bits and the output valid flag; the entry memory itself
// is not cleared, as no entry is read without its valid bit.
// If the receiver stalls, the result holds in the output register; the block
// still takes and scans the next request, but holds its result (and any table
// update) until the previous result has been taken.
module range_segment_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// s_tdata: range_base [63:0], range_size [127:64], payload_handle [191:128]
	input  logic [rseg_pkg::IN_DATA_W-1:0] s_tdata,
	// s_tuser: operation [1:0]
	input  logic [rseg_pkg::OP_W-1:0]      s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// m_tdata: found_handle [63:0]
	output logic [rseg_pkg::ADDR_W-1:0]    m_tdata,
	// m_tuser: status [1:0]
	output logic [rseg_pkg::STAT_W-1:0]    m_tuser
);
	import rseg_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	logic [1:0]             state_q;

	// request latched at accept
	logic [OP_W-1:0]        op_q;
	logic [ADDR_W-1:0]      key_start_q;
	logic [ADDR_W-1:0]      key_end_q;
	logic [ADDR_W-1:0]      key_handle_q;

	// entry memory and per-slot valid bits
	entry_t                 mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;

	// read issue side
	logic [IDX_W-1:0]       cnt_q;
	logic                   issue_done_q;
	logic                   rd_en;

	// read data stage
	entry_t                 rd_data_s1;
	logic                   rd_vld_s1;
	logic                   rd_last_s1;
	logic [IDX_W-1:0]       idx_s1;

	// scan accumulators
	logic                   hit_q;
	logic [IDX_W-1:0]       hit_idx_q;
	logic [ADDR_W-1:0]      hit_handle_q;
	logic                   ovl_q;
	logic                   free_q;
	logic [IDX_W-1:0]       free_idx_q;

	// output register
	logic                   out_vld_q;
	logic [STAT_W-1:0]      out_status_q;
	logic [ADDR_W-1:0]      out_handle_q;

	logic                   in_acc;
	logic                   slot_ok;
	logic                   finish;
	logic                   cur_vld;
	logic                   ovl_now;
	logic                   exact_now;
	logic [STAT_W-1:0]      res_status;
	logic [ADDR_W-1:0]      res_handle;
	logic                   wr_en;
	logic                   del_en;

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign slot_ok  = !out_vld_q || m_tready;
	assign finish   = (state_q == S_DONE) && slot_ok;
	assign rd_en    = (state_q == S_SCAN) && !issue_done_q;

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_handle_q;
	assign m_tuser  = out_status_q;

	// compare stage: touching endpoints count as overlap
	assign cur_vld   = rd_vld_s1 && valid_q[idx_s1];
	assign ovl_now   = cur_vld && !(rd_data_s1.end_addr < key_start_q)
	                   && !(key_end_q < rd_data_s1.start_addr);
	assign exact_now = cur_vld && (rd_data_s1.start_addr == key_start_q)
	                   && (rd_data_s1.end_addr == key_end_q);

	// result and table update, decided once the scan is complete
	always_comb begin
		res_status = STAT_ABSENT;
		res_handle = '0;
		wr_en      = 1'b0;
		del_en     = 1'b0;
		case (op_q)
			OP_INSERT: begin
				if (ovl_q) begin
					res_status = STAT_OVERLAP;
				end else if (!free_q) begin
					res_status = STAT_FULL;
				end else begin
					res_status = STAT_OK;
					wr_en      = finish;
				end
			end
			OP_FIND: begin
				if (hit_q) begin
					res_status = STAT_OK;
					res_handle = hit_handle_q;
				end else if (ovl_q) begin
					res_status = STAT_OVERLAP;
				end
			end
			OP_DELETE: begin
				if (hit_q) begin
					res_status = STAT_OK;
					del_en     = finish;
				end
			end
			default: begin
				res_status = STAT_ABSENT;
			end
		endcase
	end

	// entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[free_idx_q] <= '{start_addr: key_start_q, end_addr: key_end_q,
			                     handle: key_handle_q};
		end
		if (rd_en) begin
			rd_data_s1 <= mem[cnt_q];
		end
	end

	// request latch and accumulators, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q         <= s_tuser;
			key_start_q  <= s_tdata[ADDR_W-1:0];
			key_end_q    <= s_tdata[ADDR_W-1:0] + s_tdata[2*ADDR_W-1:ADDR_W];
			key_handle_q <= s_tdata[3*ADDR_W-1:2*ADDR_W];
		end
		if (rd_en) begin
			idx_s1     <= cnt_q;
			rd_last_s1 <= (cnt_q == LAST_IDX);
		end
		if (exact_now && !hit_q) begin
			hit_idx_q    <= idx_s1;
			hit_handle_q <= rd_data_s1.handle;
		end
		if (rd_vld_s1 && !valid_q[idx_s1] && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (finish) begin
			out_status_q <= res_status;
			out_handle_q <= res_handle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			issue_done_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			hit_q        <= 1'b0;
			ovl_q        <= 1'b0;
			free_q       <= 1'b0;
			valid_q      <= '0;
			out_vld_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			// a new result wins over the one taken in the same cycle
			if (finish) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q      <= S_SCAN;
						cnt_q        <= '0;
						issue_done_q <= 1'b0;
						hit_q        <= 1'b0;
						ovl_q        <= 1'b0;
						free_q       <= 1'b0;
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == LAST_IDX) begin
							issue_done_q <= 1'b1;
						end
					end
					if (ovl_now) begin
						ovl_q <= 1'b1;
					end
					if (exact_now) begin
						hit_q <= 1'b1;
					end
					if (rd_vld_s1 && !valid_q[idx_s1]) begin
						free_q <= 1'b1;
					end
					if (rd_vld_s1 && rd_last_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (finish) begin
						state_q <= S_IDLE;
						if (wr_en) begin
							valid_q[free_idx_q] <= 1'b1;
						end
						if (del_en) begin
							valid_q[hit_idx_q] <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/rseg_checker.sv =====
`include "range_segment_table_defines.svh"

module rseg_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [rseg_pkg::IN_DATA_W-1:0] s_tdata,
	input logic [rseg_pkg::OP_W-1:0]      s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [rseg_pkg::ADDR_W-1:0]    m_tdata,
	input logic [rseg_pkg::STAT_W-1:0]    m_tuser
);
	import rseg_pkg::*;

	// stalled result holds
	`RSEG_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// a taken request keeps the input closed while it is scanned
	`RSEG_ASSERT(a_busy_after_acc, s_tvalid && s_tready |=> !s_tready, "request taken during scan")

	// handle is only reported with a success status
	`RSEG_ASSERT(a_handle_zero, m_tvalid && (m_tuser != STAT_OK) |-> m_tdata == '0, "handle nonzero on failure")

	// no result during reset
	`RSEG_ASSERT_RST(a_reset_quiet, !arst_n |-> !m_tvalid, "result valid in reset")

endmodule

bind range_segment_table rseg_checker u_rseg_checker (.*);
